// ===== sv/framed_command_receiver_defines.svh =====
// Assertion macros shared by the framed command receiver
`ifndef FRAMED_COMMAND_RECEIVER_DEFINES_SVH
`define FRAMED_COMMAND_RECEIVER_DEFINES_SVH

// Checked outside reset
`define FCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define FCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/fcr_pkg.sv =====
// Shared types, constants and CRC function for the framed command receiver
package fcr_pkg;

  localparam int PAYLOAD_KEEP = 12;
  localparam int STORE_AW     = $clog2(PAYLOAD_KEEP);

  localparam logic [7:0]  SYNC0      = 8'hFF;
  localparam logic [7:0]  SYNC1      = 8'hFE;
  localparam logic [7:0]  ID_TWIST   = 8'h02;
  localparam logic [7:0]  ID_MODE    = 8'h03;
  localparam logic [7:0]  ID_YAW     = 8'h04;
  localparam logic [6:0]  LEN_TWIST  = 7'd12;
  localparam logic [6:0]  LEN_MODE   = 7'd2;
  localparam logic [6:0]  LIMIT_CAP  = 7'd64;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam logic [6:0]  MAX_PAYLOAD_RST   = 7'd64;
  localparam logic [7:0]  FRAME_TIMEOUT_RST = 8'd100;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_PAYLOAD   = 2'd0;
  localparam logic [1:0] REG_FRAME_TIMEOUT = 2'd1;

  // result status codes
  localparam logic [2:0] STAT_TWIST    = 3'd0;
  localparam logic [2:0] STAT_MODE     = 3'd1;
  localparam logic [2:0] STAT_YAW      = 3'd2;
  localparam logic [2:0] STAT_IGNORED  = 3'd3;
  localparam logic [2:0] STAT_CRC_BAD  = 3'd4;
  localparam logic [2:0] STAT_LEN_ABRT = 3'd5;
  localparam logic [2:0] STAT_TIMEOUT  = 3'd6;

  typedef struct packed {
    logic [6:0] max_payload;
    logic [7:0] frame_timeout;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  mode_value;
    logic [31:0] angular_z_bits;
    logic [31:0] linear_y_bits;
    logic [31:0] linear_x_bits;
    logic [7:0]  message_id;
    logic [2:0]  status;
  } result_t;

  // CRC-16/MODBUS, one byte, unrolled over eight bit steps
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/fcr_in_stage.sv =====
// Input register holding one received byte ahead of the parser
module fcr_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       adv,
  output logic       byte_valid,
  output logic [7:0] rx_byte
);

  assign s_tready = !byte_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (s_tready) begin
      byte_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rx_byte <= s_tdata;
    end
  end

endmodule

// ===== sv/fcr_parser.sv =====
// Frame parser: state, CRC, payload store and command decode for one byte
module fcr_parser (
  input  logic             clk,
  input  logic             rst,
  input  fcr_pkg::cfg_t    cfg,
  input  logic             adv,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output fcr_pkg::result_t res
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_HEADER  = 3'd1;
  localparam logic [2:0] S_ID      = 3'd2;
  localparam logic [2:0] S_LENGTH  = 3'd3;
  localparam logic [2:0] S_PAYLOAD = 3'd4;
  localparam logic [2:0] S_CRCLO   = 3'd5;
  localparam logic [2:0] S_CRCHI   = 3'd6;

  logic [2:0]  parse_state, parse_state_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [6:0]  frame_length, frame_length_next;
  logic [6:0]  payload_index, payload_index_next;
  logic [7:0]  received_crc_lo, received_crc_lo_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  payload_store [fcr_pkg::PAYLOAD_KEEP];

  logic        store_we;
  logic [7:0]  cnt_inc;
  logic [15:0] crc_b;
  logic [6:0]  limit;
  logic [6:0]  idx_inc;

  assign cnt_inc = (byte_count != 8'hFF) ? byte_count + 8'd1 : byte_count;
  assign crc_b   = fcr_pkg::crc_add(running_crc, rx_byte);
  assign limit   = (cfg.max_payload > fcr_pkg::LIMIT_CAP) ? fcr_pkg::LIMIT_CAP
                                                          : cfg.max_payload;
  assign idx_inc = payload_index + 7'd1;

  always_comb begin
    parse_state_next     = parse_state;
    frame_id_next        = frame_id;
    frame_length_next    = frame_length;
    payload_index_next   = payload_index;
    received_crc_lo_next = received_crc_lo;
    running_crc_next     = running_crc;
    byte_count_next      = cnt_inc;
    store_we             = 1'b0;
    res_valid            = 1'b0;
    res                  = '0;

    if (parse_state != S_IDLE && cnt_inc > cfg.frame_timeout) begin
      res_valid         = 1'b1;
      res.status        = fcr_pkg::STAT_TIMEOUT;
      res.message_id    = frame_id;
      parse_state_next  = S_IDLE;
      byte_count_next   = 8'd0;
    end else begin
      case (parse_state)
        S_IDLE: begin
          if (rx_byte == fcr_pkg::SYNC0) begin
            parse_state_next = S_HEADER;
            frame_id_next    = 8'd0;
          end
        end
        S_HEADER: begin
          if (rx_byte == fcr_pkg::SYNC1) begin
            parse_state_next   = S_ID;
            payload_index_next = 7'd0;
            running_crc_next   = fcr_pkg::CRC_INIT;
          end
        end
        S_ID: begin
          frame_id_next    = rx_byte;
          running_crc_next = crc_b;
          parse_state_next = S_LENGTH;
        end
        S_LENGTH: begin
          if (rx_byte > {1'b0, limit}) begin
            res_valid        = 1'b1;
            res.status       = fcr_pkg::STAT_LEN_ABRT;
            res.message_id   = frame_id;
            parse_state_next = S_IDLE;
            byte_count_next  = 8'd0;
          end else begin
            frame_length_next  = rx_byte[6:0];
            running_crc_next   = crc_b;
            payload_index_next = 7'd0;
            parse_state_next   = (rx_byte == 8'd0) ? S_CRCLO : S_PAYLOAD;
          end
        end
        S_PAYLOAD: begin
          store_we           = payload_index < 7'(fcr_pkg::PAYLOAD_KEEP);
          running_crc_next   = crc_b;
          payload_index_next = idx_inc;
          if (idx_inc >= frame_length) begin
            parse_state_next = S_CRCLO;
          end
        end
        S_CRCLO: begin
          received_crc_lo_next = rx_byte;
          parse_state_next     = S_CRCHI;
        end
        S_CRCHI: begin
          res_valid      = 1'b1;
          res.message_id = frame_id;
          if ({rx_byte, received_crc_lo} != running_crc) begin
            res.status = fcr_pkg::STAT_CRC_BAD;
          end else if (frame_id == fcr_pkg::ID_TWIST && frame_length == fcr_pkg::LEN_TWIST) begin
            res.status         = fcr_pkg::STAT_TWIST;
            res.linear_x_bits  = {payload_store[3], payload_store[2],
                                  payload_store[1], payload_store[0]};
            res.linear_y_bits  = {payload_store[7], payload_store[6],
                                  payload_store[5], payload_store[4]};
            res.angular_z_bits = {payload_store[11], payload_store[10],
                                  payload_store[9], payload_store[8]};
          end else if (frame_id == fcr_pkg::ID_MODE && frame_length == fcr_pkg::LEN_MODE) begin
            res.status     = fcr_pkg::STAT_MODE;
            res.mode_value = payload_store[0];
          end else if (frame_id == fcr_pkg::ID_YAW) begin
            res.status = fcr_pkg::STAT_YAW;
          end else begin
            res.status = fcr_pkg::STAT_IGNORED;
          end
          parse_state_next = S_IDLE;
          byte_count_next  = 8'd0;
        end
        default: begin
          parse_state_next = S_IDLE;
          byte_count_next  = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state     <= S_IDLE;
      frame_id        <= 8'd0;
      frame_length    <= 7'd0;
      payload_index   <= 7'd0;
      received_crc_lo <= 8'd0;
      running_crc     <= fcr_pkg::CRC_INIT;
      byte_count      <= 8'd0;
    end else if (adv) begin
      parse_state     <= parse_state_next;
      frame_id        <= frame_id_next;
      frame_length    <= frame_length_next;
      payload_index   <= payload_index_next;
      received_crc_lo <= received_crc_lo_next;
      running_crc     <= running_crc_next;
      byte_count      <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && store_we) begin
      payload_store[payload_index[fcr_pkg::STORE_AW-1:0]] <= rx_byte;
    end
  end

endmodule

// ===== sv/fcr_out_stage.sv =====
// Result register on the output stream
module fcr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  fcr_pkg::result_t res,
  output logic             load_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [111:0]     m_tdata,  // message_id, linear_x_bits, linear_y_bits,
                                     // angular_z_bits, mode_value
  output logic [2:0]       m_tuser   // status
);

  fcr_pkg::result_t held;

  assign load_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {held.mode_value, held.angular_z_bits, held.linear_y_bits,
                    held.linear_x_bits, held.message_id};
  assign m_tuser = held.status;

endmodule

// ===== sv/framed_command_receiver.sv =====
// Framed command receiver: serial frame parser with CRC-16 check and decode
//
// Input stream s_*: one received byte per transaction in s_tdata.
// Output stream m_*: one result per frame that ends or aborts; m_tuser is
// the status, m_tdata carries id, three raw 32-bit words and the mode byte.
// Fields that do not apply to a status are zero.
// Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (0 max_payload, 1 frame_timeout); cfg_ready is always high.
// Path: a byte is held in the input register, and its result, if any, is
// loaded into the result register when the parser advances. Throughput is
// one byte per cycle while no waiting result is held back by m_tready: the
// CRC update, state step and decode for a byte sit between the input register and the result register.
// Stalls: while m_tready is low and a result waits, the input register
// still takes one more byte; after that s_tready drops until the result
// is taken.
// Reset (rst, synchronous): parser idle, CRC at 0xFFFF, counters cleared,
// registers back to 64 and 100, both stream registers empty.
`include "framed_command_receiver_defines.svh"

module framed_command_receiver (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,    // [7:0] rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,    // [7:0] message_id, [39:8] linear_x_bits,
                                   // [71:40] linear_y_bits,
                                   // [103:72] angular_z_bits, [111:104] mode_value
  output logic [2:0]   m_tuser,    // [2:0] status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  fcr_pkg::cfg_t    cfg;
  fcr_pkg::result_t res;
  logic             res_valid;
  logic             byte_valid;
  logic [7:0]       rx_byte;
  logic             load_ready;
  logic             adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload   <= fcr_pkg::MAX_PAYLOAD_RST;
      cfg.frame_timeout <= fcr_pkg::FRAME_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == fcr_pkg::REG_MAX_PAYLOAD) begin
        cfg.max_payload <= cfg_data[6:0];
      end else if (cfg_index == fcr_pkg::REG_FRAME_TIMEOUT) begin
        cfg.frame_timeout <= cfg_data;
      end
    end
  end

  assign adv = byte_valid && load_ready;

  fcr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .adv        (adv),
    .byte_valid (byte_valid),
    .rx_byte    (rx_byte)
  );

  fcr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .adv       (adv),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  fcr_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (adv && res_valid),
    .res        (res),
    .load_ready (load_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  `FCR_ASSERT_ALWAYS(a_rst_clears_out, rst |=> !m_tvalid, "result valid after reset")
  `FCR_ASSERT(a_full_blocks_input, (byte_valid && m_tvalid && !m_tready) |-> !s_tready,
              "input taken while both stages are blocked")
  `FCR_ASSERT(a_status_range, m_tvalid |-> (m_tuser <= fcr_pkg::STAT_TIMEOUT),
              "status code out of range")
  `FCR_ASSERT(a_nontwist_words_zero,
              (m_tvalid && m_tuser != fcr_pkg::STAT_TWIST) |-> (m_tdata[103:8] == '0),
              "float words set on a non-twist result")

endmodule
